>>> rtl/asuc_pkg.sv
// ----------------------------------------------------------------------------
// asuc_pkg
// Shared types and constants for the sensor unit converter.
// ----------------------------------------------------------------------------
package asuc_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned RAW_W  = 12;
    localparam int unsigned OUT_W  = 24;
    localparam int unsigned MV_W   = 12;

    // Width of the restoring-division rows: dividends up to 32990000 (25 bits).
    localparam int unsigned DIV_W  = 25;
    localparam int unsigned DEN_W  = 13;

    typedef enum logic [KIND_W-1:0] {
        KIND_IR     = 3'd0,
        KIND_THERM  = 3'd1,
        KIND_GAS_A  = 3'd2,
        KIND_GAS_B  = 3'd3,
        KIND_ITEMP  = 3'd4,
        KIND_SUPPLY = 3'd5,
        KIND_UNK_A  = 3'd6,
        KIND_UNK_B  = 3'd7
    } t_kind;

    // Post-processing step applied after the first division.
    typedef enum logic [2:0] {
        POST_NONE   = 3'd0,
        POST_THERM  = 3'd1,
        POST_GAS    = 3'd2,
        POST_ITEMP  = 3'd3,
        POST_ZERO   = 3'd4
    } t_post;

    // Item travelling down the divider cells.
    typedef struct packed {
        logic              valid;
        t_post             post;
        logic              neg;     // negate quotient (internal temp); in the first row, marks a final supply result
        logic [DIV_W-1:0]  rem;     // partial remainder
        logic [DIV_W-1:0]  quo;     // dividend shifting out / quotient in
        logic [DEN_W-1:0]  den;
    } t_cell;

endpackage

>>> rtl/asuc_if.sv
// ----------------------------------------------------------------------------
// asuc_if
// Valid/ready stream channel carrying the converter payload.
// ----------------------------------------------------------------------------
interface asuc_in_if;
    import asuc_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] sensor_kind;
    logic [RAW_W-1:0]  raw_sample;
    modport source (output valid, sensor_kind, raw_sample, input ready);
    modport sink   (input valid, sensor_kind, raw_sample, output ready);
endinterface

interface asuc_out_if;
    import asuc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  converted_value;
    modport source (output valid, converted_value, input ready);
    modport sink   (input valid, converted_value, output ready);
endinterface

>>> rtl/adc_sensor_unit_converter.sv
// ----------------------------------------------------------------------------
// adc_sensor_unit_converter
// Converts a 12-bit sample and sensor kind into a signed engineering value.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle unless the output is stalled; each
// passes through two fully pipelined rows of 25 restoring-division cells,
// then a fit register and an output register. Stage one scales the sample
// to millivolts (multiply by 3300, divide by 4095 through the first row,
// which also serves the supply kind), stage two builds the kind's own
// dividend and divisor and passes them through the second row, and a final
// stage applies the thermistor line fit, the gas /10 and the
// internal-temperature offset. The whole pipe advances together and holds
// while the output is stalled.
module adc_sensor_unit_converter
    import asuc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    asuc_in_if.sink    i_in,
    asuc_out_if.source o_out
);
    logic w_en;
    t_cell w_a_in, w_a_out, w_b_in, w_b_out;
    t_kind w_kind;
    logic [MV_W-1:0] w_mv;
    logic [DIV_W-1:0] w_rt;
    logic [DIV_W-1:0] w_fit_num;
    logic [5:0] w_fit_den;
    logic [MV_W-1:0] w_m;

    // Advance whenever the output register is free or being drained.
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;
    assign w_kind     = t_kind'(i_in.sensor_kind);

    // First row: mv = raw*3300/4095, or 4914000/max(raw,1) for supply.
    always_comb begin
        w_a_in       = '0;
        w_a_in.valid = i_in.valid;
        w_a_in.den   = DEN_W'(4095);
        w_a_in.quo   = DIV_W'(i_in.raw_sample) * DIV_W'(3300);
        unique case (w_kind)
            KIND_IR:                 w_a_in.post = POST_NONE;
            KIND_THERM:              w_a_in.post = POST_THERM;
            KIND_GAS_A, KIND_GAS_B:  w_a_in.post = POST_GAS;
            KIND_ITEMP:              w_a_in.post = POST_ITEMP;
            KIND_SUPPLY: begin
                w_a_in.post = POST_NONE;
                w_a_in.quo  = DIV_W'(4914000);
                w_a_in.den  = (i_in.raw_sample == '0) ? DEN_W'(1)
                                                      : {1'b0, i_in.raw_sample};
                w_a_in.neg  = 1'b1; // marks "result already final"
            end
            default:                 w_a_in.post = POST_ZERO;
        endcase
    end

    asuc_div_chain u_row_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_cell(w_a_in), .o_cell(w_a_out)
    );

    assign w_mv = w_a_out.quo[MV_W-1:0];

    // Second row: the kind's own division.
    always_comb begin
        w_b_in       = '0;
        w_b_in.valid = w_a_out.valid;
        w_b_in.post  = w_a_out.post;
        w_b_in.den   = DEN_W'(1);
        w_b_in.quo   = w_a_out.quo;
        w_m          = w_mv;
        if (w_a_out.neg) begin
            w_b_in.post = POST_NONE;
        end else begin
            unique case (w_a_out.post)
                POST_THERM: begin
                    w_m         = (w_mv >= MV_W'(3300)) ? MV_W'(3299) : w_mv;
                    w_b_in.quo  = DIV_W'(w_m) * DIV_W'(10000);
                    w_b_in.den  = DEN_W'(13'd3300 - {1'b0, w_m});
                end
                POST_GAS: begin
                    w_m         = (w_mv == '0) ? MV_W'(1) : w_mv;
                    w_b_in.quo  = DIV_W'((13'd3300 - {1'b0, w_m}) * 23'd1000);
                    w_b_in.den  = {1'b0, w_m};
                end
                POST_ITEMP: begin
                    // |1430-mv|*100 / 43, sign reapplied after the division
                    if (w_mv > MV_W'(1430)) begin
                        w_b_in.neg = 1'b1;
                        w_b_in.quo = DIV_W'((w_mv - MV_W'(1430)) * 19'd100);
                    end else begin
                        w_b_in.quo = DIV_W'((MV_W'(1430) - w_mv) * 19'd100);
                    end
                    w_b_in.den = DEN_W'(43);
                end
                default: w_b_in.quo = w_a_out.quo;
            endcase
        end
    end

    asuc_div_chain u_row_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_cell(w_b_in), .o_cell(w_b_out)
    );

    // Fit stage: one small constant division, then the offset.
    assign w_rt = w_b_out.quo;
    logic signed [OUT_W-1:0] r_fit_base;
    logic [DIV_W-1:0] r_fit_num;
    logic [5:0]       r_fit_den;
    logic             r_fit_sub, r_fit_valid, r_fit_const;
    logic signed [OUT_W-1:0] r_fit_val;

    always_comb begin
        w_fit_num = '0;
        w_fit_den = 6'd1;
        if (w_rt > DIV_W'(10000)) begin
            w_fit_num = w_rt - DIV_W'(10000);
            w_fit_den = 6'd35;
        end else begin
            w_fit_num = DIV_W'(10000) - w_rt;
            w_fit_den = 6'd30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_valid <= 1'b0;
        end else if (w_en) begin
            r_fit_valid <= w_b_out.valid;
        end
        if (w_en) begin
            r_fit_const <= 1'b1;
            r_fit_sub   <= 1'b0;
            r_fit_num   <= '0;
            r_fit_den   <= 6'd1;
            r_fit_base  <= '0;
            unique case (w_b_out.post)
                POST_NONE:  r_fit_val <= OUT_W'(w_rt);
                POST_THERM: begin
                    r_fit_const <= 1'b0;
                    r_fit_num   <= w_fit_num;
                    r_fit_den   <= w_fit_den;
                    r_fit_sub   <= (w_rt > DIV_W'(10000));
                    r_fit_base  <= OUT_W'(2500);
                    r_fit_val   <= '0;
                end
                POST_GAS: begin
                    r_fit_const <= 1'b0;
                    r_fit_num   <= w_rt;
                    r_fit_den   <= 6'd10;
                    r_fit_val   <= '0;
                end
                POST_ITEMP: r_fit_val <= w_b_out.neg
                        ? OUT_W'(2500) - OUT_W'(w_rt) : OUT_W'(2500) + OUT_W'(w_rt);
                default:    r_fit_val <= '0;
            endcase
        end
    end

    // Quotient by 10, 30 or 35 through a reciprocal multiply and shift; exact
    // for every numerator below 2**DIV_W.
    logic [25:0]       w_recip;
    logic [DIV_W+25:0] w_prod;
    logic [DIV_W-1:0]  w_q;
    always_comb begin
        unique case (r_fit_den)
            6'd10:   w_recip = 26'd26843546;
            6'd30:   w_recip = 26'd35791395;
            6'd35:   w_recip = 26'd61356676;
            default: w_recip = 26'd0;
        endcase
        w_prod = {26'd0, r_fit_num} * {{DIV_W{1'b0}}, w_recip};
        unique case (r_fit_den)
            6'd10:   w_q = DIV_W'(w_prod[DIV_W+25:28]);
            6'd30:   w_q = DIV_W'(w_prod[DIV_W+25:30]);
            6'd35:   w_q = DIV_W'(w_prod[DIV_W+25:31]);
            default: w_q = r_fit_num;
        endcase
    end

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_fit_valid;
        end
        if (w_en) begin
            if (r_fit_const) begin
                r_out_val <= r_fit_val;
            end else if (r_fit_sub) begin
                r_out_val <= r_fit_base - OUT_W'(w_q);
            end else begin
                r_out_val <= r_fit_base + OUT_W'(w_q);
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.converted_value = r_out_val;

    // Hold the result while the sink stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.converted_value))
        else $error("result changed under stall");
    // Input is refused only while the output is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid && !o_out.ready)
        else $error("input refused without stall");
    // An unknown kind yields zero.
    a_unk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_fit_valid && r_fit_const && $past(w_b_out.post == POST_ZERO && w_en)
        |=> r_out_val == '0)
        else $error("unknown kind gave non-zero");
endmodule

>>> rtl/asuc_div_cell.sv
// ----------------------------------------------------------------------------
// asuc_div_cell
// One restoring-division step: shift in one dividend bit, subtract, register.
// ----------------------------------------------------------------------------
module asuc_div_cell
    import asuc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    logic [DIV_W:0] w_try;
    logic [DIV_W:0] w_sub;

    always_comb begin
        n_cell = i_cell;
        w_try  = {i_cell.rem, i_cell.quo[DIV_W-1]};
        w_sub  = w_try - {{(DIV_W+1-DEN_W){1'b0}}, i_cell.den};
        if (!w_sub[DIV_W]) begin
            n_cell.rem = w_sub[DIV_W-1:0];
        end else begin
            n_cell.rem = w_try[DIV_W-1:0];
        end
        n_cell.quo = {i_cell.quo[DIV_W-2:0], ~w_sub[DIV_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
        end
        if (i_en) begin
            r_cell.post <= n_cell.post;
            r_cell.neg  <= n_cell.neg;
            r_cell.rem  <= n_cell.rem;
            r_cell.quo  <= n_cell.quo;
            r_cell.den  <= n_cell.den;
        end
    end

    assign o_cell = r_cell;
endmodule

>>> rtl/asuc_div_chain.sv
// ----------------------------------------------------------------------------
// asuc_div_chain
// Row of DIV_W division cells; one item enters and one leaves every cycle while i_en is high.
// ----------------------------------------------------------------------------
module asuc_div_chain
    import asuc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);
    t_cell w_link [DIV_W+1];

    assign w_link[0] = i_cell;

    for (genvar g = 0; g < DIV_W; g++) begin : g_cell
        asuc_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_cell (w_link[g]),
            .o_cell (w_link[g+1])
        );
    end

    assign o_cell = w_link[DIV_W];
endmodule

>>> dv/asuc_tb_if.sv
// ----------------------------------------------------------------------------
// asuc_tb_if
// Helper types for the stand-alone bench of the converter.
// ----------------------------------------------------------------------------
// The stream interfaces themselves live with the RTL; this file only holds
// the small helper types that the bench shares between its processes.
package asuc_tb_pkg;
    import asuc_pkg::*;

    typedef struct {
        t_kind             kind;
        logic [RAW_W-1:0]  raw;
        logic              has_value;   // expected value typed in by hand
        int                value;
    } t_stim_row;
endpackage

>>> dv/adc_sensor_unit_converter_test.sv
// ----------------------------------------------------------------------------
// adc_sensor_unit_converter_test
// Self-checking bench for the sensor unit converter.
// ----------------------------------------------------------------------------
// A directed table (extremes, every kind, the clamp cases) is followed by
// random transactions. Every accepted input is run through a local predictor
// and the result queued; every accepted output is checked against the oldest
// queued value. Both sides idle at random, and the receiver once holds off
// for a long stretch so that the pipe fills and stalls its input.
module adc_sensor_unit_converter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import asuc_pkg::*;
    import asuc_tb_pkg::*;

    localparam int LATENCY   = 2 * DIV_W + 4;
    localparam int N_RANDOM  = 530;
    localparam int LONG_HOLD = 200;

    logic i_clk;
    logic i_rst_n;

    asuc_in_if  in_ch();
    asuc_out_if out_ch();

    adc_sensor_unit_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    int          expected_values[$];
    int          error_count;
    bit          stimulus_done;
    int          accepted_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Report one mismatch and count it.
    task automatic report_error(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Engineering value for one sample, worked out independently of the RTL.
    function automatic int convert_sample(input t_kind kind, input logic [RAW_W-1:0] raw);
        longint mv;
        longint m;
        longint rt;
        longint r;
        mv = (longint'(raw) * 3300) / 4095;
        case (kind)
            KIND_IR: return int'(mv);
            KIND_THERM: begin
                m  = (mv >= 3300) ? 3299 : mv;
                rt = (10000 * m) / (3300 - m);
                if (rt > 10000) return int'(2500 - (rt - 10000) / 35);
                return int'(2500 + (10000 - rt) / 30);
            end
            KIND_GAS_A, KIND_GAS_B: begin
                m = (mv < 1) ? 1 : mv;
                return int'((((3300 - m) * 1000) / m) / 10);
            end
            // SystemVerilog division truncates toward zero, as required here
            KIND_ITEMP: return int'(((1430 - mv) * 100) / 43 + 2500);
            KIND_SUPPLY: begin
                r = (raw == '0) ? 1 : longint'(raw);
                return int'((1200 * 4095) / r);
            end
            default: return 0;
        endcase
    endfunction

    // Directed table: expected values typed in only where obvious.
    t_stim_row directed_rows[$];

    task automatic add_row(input t_kind k, input logic [RAW_W-1:0] raw,
                           input logic has_v, input int v);
        t_stim_row row;
        row.kind = k;
        row.raw = raw;
        row.has_value = has_v;
        row.value = v;
        directed_rows.push_back(row);
    endtask

    initial begin
        add_row(KIND_IR,     12'd0,    1'b1, 0);
        add_row(KIND_IR,     12'd4095, 1'b1, 3300);
        add_row(KIND_IR,     12'hAAA,  1'b0, 0);
        add_row(KIND_IR,     12'h555,  1'b0, 0);
        add_row(KIND_THERM,  12'd0,    1'b1, 2500 + 10000 / 30);
        add_row(KIND_THERM,  12'd4095, 1'b0, 0);   // full scale clamps to 3299
        add_row(KIND_THERM,  12'd2048, 1'b0, 0);
        add_row(KIND_THERM,  12'd4000, 1'b0, 0);
        add_row(KIND_GAS_A,  12'd0,    1'b1, 329900); // zero reading raised to 1
        add_row(KIND_GAS_A,  12'd4095, 1'b1, 0);
        add_row(KIND_GAS_B,  12'd0,    1'b1, 329900);
        add_row(KIND_GAS_B,  12'd1000, 1'b0, 0);
        add_row(KIND_ITEMP,  12'd0,    1'b1, 143000 / 43 + 2500);
        add_row(KIND_ITEMP,  12'd4095, 1'b1, -187000 / 43 + 2500);
        add_row(KIND_ITEMP,  12'd1775, 1'b0, 0);
        add_row(KIND_SUPPLY, 12'd0,    1'b1, 4914000); // zero sample taken as 1
        add_row(KIND_SUPPLY, 12'd1,    1'b1, 4914000);
        add_row(KIND_SUPPLY, 12'd4095, 1'b1, 1200);
        add_row(KIND_SUPPLY, 12'd3000, 1'b0, 0);
        add_row(KIND_UNK_A,  12'd4095, 1'b1, 0);
        add_row(KIND_UNK_B,  12'd1234, 1'b1, 0);
    end

    // Drive one transaction at the falling edge and hold until accepted.
    task automatic send_sample(input t_kind kind, input logic [RAW_W-1:0] raw);
        in_ch.valid       <= 1'b1;
        in_ch.sensor_kind <= kind;
        in_ch.raw_sample  <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_values.push_back(convert_sample(kind, raw));
        accepted_count++;
        @(negedge i_clk);
    endtask

    // Sender: directed table first, then random with random gaps.
    initial begin
        int gap;
        t_kind k;
        logic [RAW_W-1:0] raw;
        in_ch.valid       <= 1'b0;
        in_ch.sensor_kind <= KIND_IR;
        in_ch.raw_sample  <= '0;
        i_rst_n           <= 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].has_value &&
                convert_sample(directed_rows[i].kind, directed_rows[i].raw)
                    != directed_rows[i].value)
                report_error($sformatf("table row %0d disagrees with predictor", i));
            send_sample(directed_rows[i].kind, directed_rows[i].raw);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Leave stretches without idling so the pipe runs at full rate.
            gap = ((n / 60) % 3 == 1) ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            k = t_kind'($urandom_range(0, 7));
            case ($urandom_range(0, 7))
                0: raw = '0;
                1: raw = '1;
                2: raw = RAW_W'($urandom_range(0, 8));
                3: raw = RAW_W'($urandom_range(4087, 4095));
                default: raw = RAW_W'($urandom());
            endcase
            send_sample(k, raw);
        end
        in_ch.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps going.
    initial begin
        int stall;
        int received;
        received = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (received == 40) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                stall = ((received / 70) % 3 == 2) ? 0 : $urandom_range(0, 14);
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            received++;
        end
    end

    // Check every accepted output against the oldest expectation.
    always @(posedge i_clk) begin
        int want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_values.size() == 0) begin
                report_error($sformatf("unexpected result %0d",
                             out_ch.converted_value));
            end else begin
                want = expected_values.pop_front();
                if (out_ch.converted_value !== OUT_W'(want))
                    report_error($sformatf("converted_value got %0d want %0d",
                                 out_ch.converted_value, want));
            end
        end
    end

    // Drain, wait out the latency, then give the verdict.
    initial begin
        wait (stimulus_done);
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
